// ===== rtl/mrx_pkg.sv =====
// Package for the modem receive block: item types, codes, sizes and characters.
`default_nettype none
package mrx_pkg;

    // Store sizes.
    localparam int LINE_DEPTH  = 64;
    localparam int FRAME_DEPTH = 512;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    // Copy of the first bytes of a line, used for prefix checks.
    localparam int HEAD_LEN = 6;
    localparam int HEAD_AW  = $clog2(HEAD_LEN);

    // Command queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Characters.
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_S     = 8'h53;
    localparam logic [7:0] C_G     = 8'h47;
    localparam logic [7:0] C_O     = 8'h4F;
    localparam logic [7:0] C_K     = 8'h4B;
    localparam logic [7:0] C_R     = 8'h52;
    localparam logic [7:0] C_Y     = 8'h59;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_X     = 8'h58;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_B     = 8'h42;
    localparam logic [7:0] C_D     = 8'h44;
    localparam logic [7:0] C_I     = 8'h49;
    localparam logic [7:0] C_N     = 8'h4E;
    localparam logic [7:0] C_E     = 8'h45;
    localparam logic [7:0] C_A     = 8'h41;

    typedef enum logic [2:0] {
        OP_BYTE       = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_ARM        = 3'd2,
        OP_READ_LINE  = 3'd3,
        OP_READ_FRAME = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_NONE,
        K_BYTE,
        K_RELEASE,
        K_ARM,
        K_READ_LINE,
        K_READ_FRAME
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TEXT    = 3'd1,
        EV_DONE    = 3'd2,
        EV_RING    = 3'd3,
        EV_PAYLOAD = 3'd4,
        EV_GOOD    = 3'd5,
        EV_BAD     = 3'd6,
        EV_READ    = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        CL_OTHER = 3'd0,
        CL_OK    = 3'd1,
        CL_READY = 3'd2,
        CL_SBDIX = 3'd3,
        CL_ZERO  = 3'd4
    } t_class;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO
    } t_phase;

    typedef enum logic [1:0] {
        DS_REG,
        DS_LINE,
        DS_FRAME
    } t_dsel;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] rx_byte;
        logic [8:0] read_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data;
        logic [15:0] count;
        logic [2:0]  line_class;
        logic        overflow;
    } t_out_item;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        logic [8:0] read_addr;
        logic       is_cr;
        logic       is_lf;
        logic       is_g;
    } t_cmd;

    // Status of the back for the checks at the top level.
    typedef struct packed {
        logic text_mode;
        logic line_ready;
        logic line_empty;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== rtl/mrx_front.sv =====
// Front of the modem receive block: accepts input items and classifies them.
`default_nettype none
module mrx_front (
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  mrx_pkg::t_in_item     i_in_item,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output mrx_pkg::t_cmd         o_cmd
);
    import mrx_pkg::*;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.rx_byte   = i_in_item.rx_byte;
        o_cmd.read_addr = i_in_item.read_addr;
        o_cmd.is_cr     = (i_in_item.rx_byte == C_CR);
        o_cmd.is_lf     = (i_in_item.rx_byte == C_LF);
        o_cmd.is_g      = (i_in_item.rx_byte == C_G);
        unique case (i_in_item.op)
            OP_BYTE:       o_cmd.kind = K_BYTE;
            OP_RELEASE:    o_cmd.kind = K_RELEASE;
            OP_ARM:        o_cmd.kind = K_ARM;
            OP_READ_LINE:  o_cmd.kind = K_READ_LINE;
            OP_READ_FRAME: o_cmd.kind = K_READ_FRAME;
            default:       o_cmd.kind = K_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/mrx_queue.sv =====
// Short command queue between the front and the back of the modem receive block.
`default_nettype none
module mrx_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  mrx_pkg::t_cmd    i_push_cmd,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_valid,
    output mrx_pkg::t_cmd    o_cmd
);
    import mrx_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count,  n_count;
    logic                do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QUEUE_CW'(i_push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrx_back.sv =====
// Back of the modem receive block: line and frame state, both stores, result register.
`default_nettype none
module mrx_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  mrx_pkg::t_cmd        i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output mrx_pkg::t_out_item   o_out_item,
    output mrx_pkg::t_back_stat  o_stat
);
    import mrx_pkg::*;

    // Architectural state.
    t_phase              r_phase, n_phase;
    logic [LINE_AW-1:0]  r_line_len, n_line_len;
    logic                r_line_ready, n_line_ready;
    logic [15:0]         r_frame_len, n_frame_len;
    logic [15:0]         r_frame_index, n_frame_index;
    logic [15:0]         r_run_sum, n_run_sum;
    logic [7:0]          r_sum_hi, n_sum_hi;
    logic [7:0]          r_head [HEAD_LEN];

    // Stores and their registered read ports.
    logic [7:0]          line_mem  [LINE_DEPTH];
    logic [7:0]          frame_mem [FRAME_DEPTH];
    logic [7:0]          r_line_q;
    logic [7:0]          r_frame_q;

    // Result register.
    logic                r_out_valid;
    t_out_item           r_out, n_out;
    t_dsel               r_dsel, n_dsel;

    logic                fire;
    logic                line_we, frame_we, head_we;
    logic                line_rd, frame_rd;
    logic [15:0]         addr_ext;
    logic [15:0]         index_next;
    logic [15:0]         len_next;
    logic                ring_match;
    t_class              line_cls;

    assign fire     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop    = fire;
    assign addr_ext = 16'(i_cmd.read_addr);
    assign line_rd  = fire && (i_cmd.kind == K_READ_LINE);
    assign frame_rd = fire && (i_cmd.kind == K_READ_FRAME);

    assign ring_match = (r_head[0] == C_S) && (r_head[1] == C_B) && (r_head[2] == C_D) &&
                        (r_head[3] == C_R) && (r_head[4] == C_I) && (r_head[5] == C_N);

    // Prefix class of the current line; only the first bytes take part.
    always_comb begin
        priority if (r_line_len >= LINE_AW'(2) && r_head[0] == C_O && r_head[1] == C_K) begin
            line_cls = CL_OK;
        end else if (r_line_len >= LINE_AW'(5) && r_head[0] == C_R && r_head[1] == C_E &&
                     r_head[2] == C_A && r_head[3] == C_D && r_head[4] == C_Y) begin
            line_cls = CL_READY;
        end else if (r_line_len >= LINE_AW'(6) && r_head[0] == C_PLUS &&
                     r_head[1] == C_S && r_head[2] == C_B && r_head[3] == C_D &&
                     r_head[4] == C_I && r_head[5] == C_X) begin
            line_cls = CL_SBDIX;
        end else if (r_line_len >= LINE_AW'(1) && r_head[0] == C_ZERO) begin
            line_cls = CL_ZERO;
        end else begin
            line_cls = CL_OTHER;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_line_len    = r_line_len;
        n_line_ready  = r_line_ready;
        n_frame_len   = r_frame_len;
        n_frame_index = r_frame_index;
        n_run_sum     = r_run_sum;
        n_sum_hi      = r_sum_hi;
        n_out         = '0;
        n_dsel        = DS_REG;
        line_we       = 1'b0;
        frame_we      = 1'b0;
        head_we       = 1'b0;
        index_next    = r_frame_index + 16'd1;
        len_next      = {r_frame_len[15:8], i_cmd.rx_byte};
        n_out.event_res = EV_NONE;

        unique case (i_cmd.kind)
            K_BYTE: begin
                if (r_phase == PH_TEXT) begin
                    if (i_cmd.is_cr || r_line_ready) begin
                        n_out.event_res = EV_NONE;
                    end else if (i_cmd.is_lf && r_line_len == '0) begin
                        n_out.event_res = EV_NONE;
                    end else if (i_cmd.is_g && r_line_len == LINE_AW'(HEAD_LEN) &&
                                 ring_match) begin
                        n_line_ready    = 1'b0;
                        n_line_len      = '0;
                        n_out.event_res = EV_RING;
                    end else if (i_cmd.is_lf) begin
                        n_line_ready     = 1'b1;
                        n_out.event_res  = EV_DONE;
                        n_out.count      = 16'(r_line_len);
                        n_out.line_class = line_cls;
                    end else if (r_line_len < LINE_AW'(LINE_DEPTH - 1)) begin
                        line_we         = 1'b1;
                        head_we         = (r_line_len < LINE_AW'(HEAD_LEN));
                        n_line_len      = r_line_len + 1'b1;
                        n_out.event_res = EV_TEXT;
                        n_out.data      = i_cmd.rx_byte;
                        n_out.count     = 16'(r_line_len) + 16'd1;
                    end
                end else begin
                    unique case (r_phase)
                        PH_LEN_HI: begin
                            n_frame_len = {i_cmd.rx_byte, 8'h00};
                            n_phase     = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            n_frame_len   = len_next;
                            n_run_sum     = '0;
                            n_frame_index = '0;
                            n_phase       = (len_next == '0) ? PH_SUM_HI : PH_DATA;
                        end
                        PH_DATA: begin
                            n_out.event_res = EV_PAYLOAD;
                            n_out.data      = i_cmd.rx_byte;
                            n_out.count     = r_frame_index;
                            if (r_frame_index < 16'(FRAME_DEPTH)) begin
                                frame_we = 1'b1;
                            end else begin
                                n_out.overflow = 1'b1;
                            end
                            n_run_sum     = r_run_sum + 16'(i_cmd.rx_byte);
                            n_frame_index = index_next;
                            if (index_next >= r_frame_len) begin
                                n_phase = PH_SUM_HI;
                            end
                        end
                        PH_SUM_HI: begin
                            n_sum_hi = i_cmd.rx_byte;
                            n_phase  = PH_SUM_LO;
                        end
                        PH_SUM_LO: begin
                            n_out.event_res = ({r_sum_hi, i_cmd.rx_byte} == r_run_sum) ?
                                              EV_GOOD : EV_BAD;
                            n_out.count     = r_frame_len;
                            n_out.overflow  = (r_frame_len > 16'(FRAME_DEPTH));
                            n_phase         = PH_TEXT;
                        end
                        default: begin
                            n_phase = PH_TEXT;
                        end
                    endcase
                end
            end
            K_RELEASE: begin
                n_line_ready = 1'b0;
                n_line_len   = '0;
            end
            K_ARM: begin
                n_line_ready  = 1'b0;
                n_line_len    = '0;
                n_frame_len   = '0;
                n_frame_index = '0;
                n_run_sum     = '0;
                n_sum_hi      = '0;
                n_phase       = PH_LEN_HI;
            end
            K_READ_LINE: begin
                n_out.event_res = EV_READ;
                n_out.count     = 16'(r_line_len);
                n_dsel = (addr_ext < 16'(LINE_DEPTH)) ? DS_LINE : DS_REG;
            end
            K_READ_FRAME: begin
                n_out.event_res = EV_READ;
                n_out.count     = r_frame_len;
                n_dsel = (addr_ext < 16'(FRAME_DEPTH)) ? DS_FRAME : DS_REG;
            end
            default: begin
                n_out.event_res = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TEXT;
            r_line_len    <= '0;
            r_line_ready  <= 1'b0;
            r_frame_len   <= '0;
            r_frame_index <= '0;
            r_run_sum     <= '0;
            r_sum_hi      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_phase       <= n_phase;
                r_line_len    <= n_line_len;
                r_line_ready  <= n_line_ready;
                r_frame_len   <= n_frame_len;
                r_frame_index <= n_frame_index;
                r_run_sum     <= n_run_sum;
                r_sum_hi      <= n_sum_hi;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out  <= n_out;
            r_dsel <= n_dsel;
        end
        if (fire && head_we) begin
            r_head[r_line_len[HEAD_AW-1:0]] <= i_cmd.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && line_we) begin
            line_mem[r_line_len] <= i_cmd.rx_byte;
        end
        if (line_rd) begin
            r_line_q <= line_mem[addr_ext[LINE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && frame_we) begin
            frame_mem[r_frame_index[FRAME_AW-1:0]] <= i_cmd.rx_byte;
        end
        if (frame_rd) begin
            r_frame_q <= frame_mem[addr_ext[FRAME_AW-1:0]];
        end
    end

    always_comb begin
        o_out_item = r_out;
        unique case (r_dsel)
            DS_LINE:  o_out_item.data = r_line_q;
            DS_FRAME: o_out_item.data = r_frame_q;
            default:  o_out_item.data = r_out.data;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.text_mode  = (r_phase == PH_TEXT);
    assign o_stat.line_ready = r_line_ready;
    assign o_stat.line_empty = (r_line_len == '0);

endmodule
`default_nettype wire

// ===== rtl/modem_rx_line_and_frame_receiver.sv =====
// Top level of the modem receive block: line receiver and binary frame receiver.
//
//  Channel  Dir  Handshake                  Payload fields
//  in       in   i_in_valid / o_in_ready    op, rx_byte, read_addr
//  out      out  o_out_valid / i_out_ready  event_res, data, count, line_class, overflow
//
// Every accepted item yields one result item; with the output ready it passes through
// the queue and then the result register, and one item per cycle is sustained.
// Reset is synchronous and active low; it clears the queue, the mode and the counters,
// while the stores need no clearing pass.
// An output stall holds only the result register; the two-entry queue keeps taking
// items until it is full, and then input ready drops.
`default_nettype none
module modem_rx_line_and_frame_receiver (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  mrx_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output mrx_pkg::t_out_item   o_out_item
);
    import mrx_pkg::*;

    // The front decodes the op code and flags the special characters once, so the
    // back only has to look at a few single-bit flags per byte.
    logic       push;
    logic       q_full;
    t_cmd       push_cmd;

    // Queue output toward the back.
    logic       q_valid;
    logic       q_pop;
    t_cmd       q_cmd;

    t_back_stat stat;

    mrx_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // The queue decouples input acceptance from the result register, so an input
    // item is taken even while a finished result waits to be collected, until the queue is full.
    mrx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    // The back holds the text and frame state machines, the line store, a copy of
    // the first six line bytes for prefix matching, the frame store and the result
    // register. Store reads land in registers on the same edge as the result.
    mrx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_stat      (stat)
    );

`ifndef NO_ASSERTIONS
    // A reported line stays pending: nothing after it runs while it is shown.
    a_done_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_res == EV_DONE) |-> stat.line_ready)
        else $error("line done shown without a pending line");

    // A ring alert leaves an empty, unblocked line.
    a_ring_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_res == EV_RING) |->
        (!stat.line_ready && stat.line_empty))
        else $error("ring alert left line state behind");

    // A checked frame always returns the block to text mode.
    a_frame_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.event_res == EV_GOOD ||
                         o_out_item.event_res == EV_BAD)) |-> stat.text_mode)
        else $error("frame result shown outside text mode");

    // A payload byte that is not flagged as overflow lies inside the frame store.
    a_payload_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_res == EV_PAYLOAD && !o_out_item.overflow) |->
        (o_out_item.count < 16'(FRAME_DEPTH)))
        else $error("stored payload index beyond frame store");
`endif

endmodule
`default_nettype wire

// ===== bench/modem_rx_line_and_frame_receiver_test.sv =====
// Testbench for the modem receive block: line and frame traffic checked against a predictor.
`timescale 1ns / 1ps

module modem_rx_line_and_frame_receiver_test;

    import mrx_pkg::*;

    // The unused op codes must be ignored by the block.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam int ADDR_TOP      = 511;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_EVERY    = 2500;
    localparam int HOLD_CYCLES   = 250;

    // The predictor keeps its own copy of the block state. It also records which
    // store entries have been written, so that read-backs only ever hit written
    // entries or addresses outside the line store.
    class frame_line_scoreboard;
        logic [7:0]  line_mem [LINE_DEPTH];
        logic [7:0]  frame_mem [FRAME_DEPTH];
        bit          line_mark [LINE_DEPTH];
        bit          frame_mark [FRAME_DEPTH];
        int          line_written [$];
        int          frame_written [$];
        t_phase      phase = PH_TEXT;
        int          line_len = 0;
        bit          line_ready = 0;
        logic [15:0] frame_len = '0;
        logic [15:0] frame_index = '0;
        logic [15:0] running_sum = '0;
        logic [15:0] remote_sum = '0;
        t_out_item   expected_events [$];
        int          errors = 0;
        int          results = 0;
        int          items = 0;
        int          event_tally [8];

        function int pending();
            return expected_events.size();
        endfunction

        function bit has_prefix(string p);
            if (line_len < p.len()) return 0;
            for (int i = 0; i < p.len(); i++)
                if (line_mem[i] != p[i]) return 0;
            return 1;
        endfunction

        function t_class classify_line();
            if (has_prefix("OK")) return CL_OK;
            if (has_prefix("READY")) return CL_READY;
            if (has_prefix("+SBDIX")) return CL_SBDIX;
            if (has_prefix("0")) return CL_ZERO;
            return CL_OTHER;
        endfunction

        function void take_text_byte(logic [7:0] c, inout t_out_item r);
            if (c == C_CR || line_ready) return;
            if (c == C_LF && line_len == 0) return;
            // The ring alert only counts with exactly six bytes in the line.
            if (c == C_G && line_len == 6 && has_prefix("SBDRIN")) begin
                line_ready = 0;
                line_len = 0;
                r.event_res = EV_RING;
                return;
            end
            if (c == C_LF) begin
                line_ready = 1;
                r.event_res = EV_DONE;
                r.count = 16'(line_len);
                r.line_class = classify_line();
                return;
            end
            if (line_len < LINE_DEPTH - 1) begin
                line_mem[line_len] = c;
                if (!line_mark[line_len]) begin
                    line_mark[line_len] = 1;
                    line_written.push_back(line_len);
                end
                line_len++;
                r.event_res = EV_TEXT;
                r.data = c;
                r.count = 16'(line_len);
            end
        endfunction

        function void take_frame_byte(logic [7:0] c, inout t_out_item r);
            case (phase)
                PH_LEN_HI: begin
                    frame_len = {c, 8'h00};
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len = {frame_len[15:8], c};
                    running_sum = '0;
                    frame_index = '0;
                    phase = (frame_len == 0) ? PH_SUM_HI : PH_DATA;
                end
                PH_DATA: begin
                    r.event_res = EV_PAYLOAD;
                    r.data = c;
                    r.count = frame_index;
                    if (frame_index < FRAME_DEPTH) begin
                        frame_mem[frame_index] = c;
                        if (!frame_mark[frame_index]) begin
                            frame_mark[frame_index] = 1;
                            frame_written.push_back(int'(frame_index));
                        end
                    end else begin
                        r.overflow = 1'b1;
                    end
                    running_sum = running_sum + 16'(c);
                    frame_index = frame_index + 16'd1;
                    if (frame_index >= frame_len) phase = PH_SUM_HI;
                end
                PH_SUM_HI: begin
                    remote_sum = {c, 8'h00};
                    phase = PH_SUM_LO;
                end
                default: begin
                    remote_sum = {remote_sum[15:8], c};
                    r.event_res = (remote_sum == running_sum) ? EV_GOOD : EV_BAD;
                    r.count = frame_len;
                    r.overflow = (frame_len > FRAME_DEPTH);
                    phase = PH_TEXT;
                end
            endcase
        endfunction

        function t_out_item predict_receive(t_in_item it);
            t_out_item r;
            r = '0;
            case (it.op)
                OP_BYTE: begin
                    if (phase == PH_TEXT) take_text_byte(it.rx_byte, r);
                    else take_frame_byte(it.rx_byte, r);
                end
                OP_RELEASE: begin
                    line_ready = 0;
                    line_len = 0;
                end
                OP_ARM: begin
                    line_ready = 0;
                    line_len = 0;
                    frame_len = '0;
                    frame_index = '0;
                    running_sum = '0;
                    remote_sum = '0;
                    phase = PH_LEN_HI;
                end
                OP_READ_LINE: begin
                    r.event_res = EV_READ;
                    r.data = (it.read_addr < LINE_DEPTH) ? line_mem[it.read_addr] : 8'h00;
                    r.count = 16'(line_len);
                end
                OP_READ_FRAME: begin
                    r.event_res = EV_READ;
                    r.data = frame_mem[it.read_addr];
                    r.count = frame_len;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(t_in_item it);
            items++;
            expected_events.push_back(predict_receive(it));
        endfunction

        task report_mismatch(string msg);
            if (errors < 30) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, event %0d",
                                          got.event_res));
                return;
            end
            want = expected_events.pop_front();
            results++;
            event_tally[want.event_res]++;
            if (got.event_res !== want.event_res)
                report_mismatch($sformatf("result %0d: event %0d, wanted %0d",
                                          results, got.event_res, want.event_res));
            if (got.data !== want.data)
                report_mismatch($sformatf("result %0d: data %h, wanted %h",
                                          results, got.data, want.data));
            if (got.count !== want.count)
                report_mismatch($sformatf("result %0d: count %0d, wanted %0d",
                                          results, got.count, want.count));
            if (got.line_class !== want.line_class)
                report_mismatch($sformatf("result %0d: class %0d, wanted %0d",
                                          results, got.line_class, want.line_class));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("result %0d: overflow %b, wanted %b",
                                          results, got.overflow, want.overflow));
        endtask
    endclass

    // One queued stimulus entry. Read-backs can have their address chosen when
    // the entry is sent, and an entry can ask the sender to drain the block first.
    typedef struct {
        t_in_item item;
        bit       pick_addr;
        bit       drain;
    } stim_entry_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    frame_line_scoreboard sb = new();
    stim_entry_t stim_q [$];
    bit drain_next = 0;
    int seq_count = 0;

    modem_rx_line_and_frame_receiver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Appends one item to the stimulus queue. The first item of a sequence
    // carries the drain request if the sequence asked for one.
    task automatic push_item(logic [2:0] op, logic [7:0] b, logic [8:0] a = '0,
                             bit pick = 0);
        stim_entry_t e;
        e.item.op = op;
        e.item.rx_byte = b;
        e.item.read_addr = a;
        e.pick_addr = pick;
        e.drain = drain_next;
        drain_next = 0;
        stim_q.push_back(e);
    endtask

    // A complete binary frame: arm, big-endian length, payload, checksum, and a
    // few read-backs of the frame store.
    task automatic queue_frame(int len, bit good);
        logic [15:0] flen;
        logic [15:0] sum;
        logic [7:0]  b;
        flen = 16'(len);
        sum = '0;
        push_item(OP_ARM, 8'($urandom));
        push_item(OP_BYTE, flen[15:8]);
        push_item(OP_BYTE, flen[7:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + 16'(b);
            push_item(OP_BYTE, b);
        end
        if (!good) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        push_item(OP_BYTE, sum[15:8]);
        push_item(OP_BYTE, sum[7:0]);
        repeat ($urandom_range(0, 3)) push_item(OP_READ_FRAME, 8'($urandom), '0, 1);
    endtask

    // The random part is made of sequences. Most are well-formed text lines or
    // frames with random content; the rest are broken frames and plain noise.
    task automatic build_sequence();
        int         kind;
        int         n;
        string      head;
        logic [7:0] b;
        seq_count++;
        drain_next = (seq_count == 1) || ($urandom_range(0, 39) == 0);
        kind = $urandom_range(0, 99);
        if (seq_count == 8) begin
            // One frame longer than the frame store early on, so that the whole
            // store is written and the overflow path is exercised.
            queue_frame($urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 64), 1);
        end else if (kind < 50) begin
            case ($urandom_range(0, 8))
                0: head = "OK";
                1: head = "READY";
                2: head = "+SBDIX";
                3: head = "0";
                4: head = "SBDRING";
                5: head = "SBDRIN";
                6: head = "SBD";
                7: head = "O";
                default: head = "";
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
            if (head.len() == 0 && n == 0) n = 1;
            for (int i = 0; i < head.len(); i++) begin
                if ($urandom_range(0, 9) == 0) push_item(OP_BYTE, C_CR);
                push_item(OP_BYTE, head[i]);
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) push_item(OP_BYTE, C_CR);
                b = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
                push_item(OP_BYTE, b);
            end
            push_item(OP_BYTE, C_LF);
            // Bytes while the line is pending are dropped.
            repeat ($urandom_range(0, 2)) push_item(OP_BYTE, 8'($urandom));
            repeat ($urandom_range(0, 2)) push_item(OP_READ_LINE, 8'($urandom), '0, 1);
            if ($urandom_range(0, 7) != 0) push_item(OP_RELEASE, 8'($urandom));
        end else if (kind < 82) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
            if ($urandom_range(0, 59) == 0) n = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 32);
            queue_frame(n, $urandom_range(0, 3) != 0);
        end else if (kind < 92) begin
            // A frame cut short, possibly with a release or a read in the middle,
            // then re-armed and received in full.
            push_item(OP_ARM, 8'($urandom));
            push_item(OP_BYTE, 8'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                push_item(OP_BYTE, 8'($urandom));
                repeat ($urandom_range(0, 4)) push_item(OP_BYTE, 8'($urandom));
            end
            if ($urandom_range(0, 1) == 0) push_item(OP_RELEASE, 8'($urandom));
            if ($urandom_range(0, 1) == 0) push_item(OP_READ_FRAME, 8'($urandom), '0, 1);
            queue_frame($urandom_range(0, 12), 1);
        end else begin
            // Noise stays out of binary mode, so arming is swapped for a byte.
            repeat ($urandom_range(1, 6)) begin
                b = 8'($urandom);
                n = $urandom_range(0, 7);
                if (3'(n) == OP_ARM) n = OP_BYTE;
                push_item(3'(n), b, 9'($urandom), 1);
            end
        end
    endtask

    // Chooses a read-back address: a written entry, or for the line store now
    // and then an address beyond its end.
    function automatic t_in_item resolve_read(t_in_item it);
        if (it.op == OP_READ_FRAME && sb.frame_written.size() == 0) it.op = OP_READ_LINE;
        if (it.op == OP_READ_FRAME)
            it.read_addr = 9'(sb.frame_written[$urandom_range(0, sb.frame_written.size() - 1)]);
        else if (it.op == OP_READ_LINE) begin
            if (sb.line_written.size() == 0 || $urandom_range(0, 3) == 0)
                it.read_addr = 9'($urandom_range(LINE_DEPTH, ADDR_TOP));
            else
                it.read_addr = 9'(sb.line_written[$urandom_range(0, sb.line_written.size() - 1)]);
        end
        return it;
    endfunction

    // Offers one item and holds it until the block takes it. The predictor is
    // updated at the accepting edge, before the next item is chosen.
    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    // Directed opening: ignored op codes, dropped CR, skipped empty line, a
    // classified line with bytes arriving while it is pending, read-backs in and
    // out of range, a too-short line over stale store contents, re-arming in the
    // middle of a length, and a zero-length frame with a wrong checksum.
    task automatic load_directed();
        push_item(OP_SPARE_A, 8'hFF, 9'h1FF);
        push_item(OP_SPARE_B, 8'h00, 9'h000);
        push_item(OP_SPARE_C, 8'hA5, 9'h155);
        push_item(OP_BYTE, C_CR);
        push_item(OP_BYTE, C_LF);
        push_item(OP_BYTE, C_O);
        push_item(OP_BYTE, C_K);
        push_item(OP_BYTE, C_CR);
        push_item(OP_BYTE, C_LF);
        push_item(OP_BYTE, C_X);
        push_item(OP_READ_LINE, 8'h00, 9'd0);
        push_item(OP_READ_LINE, 8'hFF, 9'(ADDR_TOP));
        push_item(OP_RELEASE, 8'h00);
        push_item(OP_BYTE, C_O);
        push_item(OP_BYTE, C_LF);
        push_item(OP_RELEASE, 8'hFF);
        push_item(OP_ARM, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_ARM, 8'hFF);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'hFF);
    endtask

    // Sender: reset, then bursts of items with random gaps. Some sequences ask
    // the sender to stop until every outstanding result has come back.
    initial begin : stimulus
        stim_entry_t e;
        int accepted;
        int target;
        int burst_left;
        int gap;
        accepted = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_directed();
        target = stim_q.size() + RANDOM_ITEMS;
        burst_left = $urandom_range(1, 32);
        while (accepted < target) begin
            if (stim_q.size() == 0) build_sequence();
            e = stim_q.pop_front();
            if (e.drain) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            if (e.pick_addr) e.item = resolve_read(e.item);
            send_item(e.item);
            accepted++;
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 32);
            end
        end
        i_in_valid <= 1'b0;

        // Every item yields one result, so the queue empties once the block drains.
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d items, %0d results: %0d text bytes, %0d lines, %0d rings",
                 sb.items, sb.results, sb.event_tally[EV_TEXT], sb.event_tally[EV_DONE],
                 sb.event_tally[EV_RING]);
        $display("  %0d payload bytes, %0d good and %0d bad frames, %0d read-backs",
                 sb.event_tally[EV_PAYLOAD], sb.event_tally[EV_GOOD],
                 sb.event_tally[EV_BAD], sb.event_tally[EV_READ]);
        if (sb.errors == 0)
            $display("modem_rx_line_and_frame_receiver_test: clean");
        else
            $display("modem_rx_line_and_frame_receiver_test: errors");
        $finish;
    end

    // Receiver: ready follows a random 16-bit pattern that is redrawn when its
    // random run ends, all ones now and then. On a fixed schedule it holds off
    // for a long stretch so that the block fills up and stops taking input.
    initial begin : result_sink
        int          cyc;
        int          hold_left;
        int          mode_left;
        logic [15:0] pattern;
        cyc = 0;
        hold_left = 0;
        mode_left = 0;
        pattern = '1;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_left == 0 && cyc % HOLD_EVERY == 400) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(50, 300);
                    pattern = 16'($urandom) | 16'h0001;
                    if ($urandom_range(0, 3) == 0) pattern = '1;
                end
                mode_left--;
                i_out_ready <= pattern[cyc % 16];
            end
        end
    end

    // Results are taken at the edge where valid and ready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("modem_rx_line_and_frame_receiver_test: errors");
        $finish;
    end

endmodule
